>>> rtl/core/ssa_pkg.sv
// Shared types and constants for the ascending set sorter.
// Used by the insertion cells, the controller and the top level.
package ssa_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // One element slot: a value and whether it holds anything.
  typedef struct packed {
    logic vld;
    val_t val;
  } elem_t;

  // Controls broadcast from the controller to the cell chain.
  typedef struct packed {
    logic insert;  // cell 0 takes the input beat this cycle
    logic shift;   // whole chain moves one place toward cell 0
  } chain_ctrl_t;

endpackage

>>> rtl/core/ssa_cell.sv
// One insertion cell of the sorting chain: keeps the smaller of its held and
// arriving value, hands the larger to the next cell. Depends on ssa_pkg.
module ssa_cell
  import ssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift,
  input  elem_t       ins,     // arriving element from the left neighbor
  input  elem_t       nb,      // held element of the right neighbor
  output elem_t       held,
  output elem_t       pass     // element handed to the right neighbor
);

  elem_t held_r, held_nxt;
  elem_t pass_r, pass_nxt;

  always_comb begin
    held_nxt = held_r;
    pass_nxt = pass_r;
    pass_nxt.vld = 1'b0;
    if (shift) begin
      held_nxt = nb;
    end else if (ins.vld) begin
      if (!held_r.vld) begin
        held_nxt = ins;
      end else if (ins.val < held_r.val) begin
        held_nxt.val = ins.val;
        pass_nxt     = held_r;
      end else begin
        pass_nxt = ins;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.vld <= 1'b0;
      pass_r.vld <= 1'b0;
    end else begin
      held_r.vld <= held_nxt.vld;
      pass_r.vld <= pass_nxt.vld;
    end
    held_r.val <= held_nxt.val;
    pass_r.val <= pass_nxt.val;
  end

  assign held = held_r;
  assign pass = pass_r;

endmodule

>>> rtl/core/ssa_ctrl.sv
// Load / settle / emit sequencer for the sorting chain.
// Keeps element count and drop flag. Depends on ssa_pkg.
module ssa_ctrl
  import ssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tlast,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,
  output logic        out_dropped,
  output chain_ctrl_t ctl
);

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  cnt_t   wait_r, wait_nxt;
  logic   ovf_r, ovf_nxt;
  logic   in_beat, out_beat, has_room;

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_EMIT);
  assign in_beat    = in_tvalid && in_tready;
  assign out_beat   = out_tvalid && out_tready;
  assign has_room   = (count_r < CNT_W'(CAPACITY));

  assign out_tlast   = (count_r == CNT_W'(1));
  assign out_dropped = ovf_r;

  assign ctl.insert = in_beat && has_room;
  assign ctl.shift  = out_beat;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    wait_nxt  = wait_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (in_beat) begin
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            // let in-flight passes reach their cell before emitting
            wait_nxt  = count_nxt;
            state_nxt = ST_SETTLE;
          end
        end
      end
      ST_SETTLE: begin
        if (wait_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          wait_nxt = wait_r - CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      wait_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wait_r  <= wait_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

>>> rtl/core/sort_set_ascending_top.sv
// Ascending set sorter: systolic insertion chain of CAPACITY cells.
// Load: one beat per cycle; each value ripples down the chain one cell a cycle.
// After the closing beat the chain settles, then emits one sorted beat per
// cycle from cell 0 while out_tready is high, as the chain shifts toward it.
// Reset (rst_n low, synchronous) clears state, count, drop flag and valid bits.
module sort_set_ascending_top
  import ssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // final_res
  output logic        out_tuser   // [0] dropped
);

  chain_ctrl_t ctl;
  elem_t       held  [CAPACITY];
  elem_t       pass  [CAPACITY];
  elem_t       ins   [CAPACITY];
  elem_t       nb    [CAPACITY];

  ssa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tlast    (in_tlast),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tlast   (out_tlast),
    .out_dropped (out_tuser),
    .ctl         (ctl)
  );

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign ins[i] = '{vld: ctl.insert, val: val_t'(in_tdata)};
      end else begin : g_body
        assign ins[i] = pass[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign nb[i] = '{vld: 1'b0, val: '0};
      end else begin : g_mid
        assign nb[i] = held[i+1];
      end
      ssa_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ctl.shift),
        .ins   (ins[i]),
        .nb    (nb[i]),
        .held  (held[i]),
        .pass  (pass[i])
      );
    end
  endgenerate

  assign out_tdata = held[0].val;

endmodule
